// ===== hdl/ijhm_pkg.sv =====
// Package for the interval jitter histogram monitor.
// Holds field widths, command and register codes, reset values and shared structs.
// No dependencies.
package ijhm_pkg;

   localparam int NS_W   = 32;
   localparam int CNT_W  = 32;
   localparam int SUM_W  = 48;
   localparam int PCT_W  = 25;
   localparam int FRAC_W = 16;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 32;

   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_REPORT = 1'b1;

   localparam logic [CSR_IDX_W-1:0] REG_PERIOD   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_FRACTION = 1'b1;

   localparam logic [NS_W-1:0]   PERIOD_RST   = 32'd16666666;
   localparam logic [FRAC_W-1:0] FRACTION_RST = 16'd64880;

   localparam logic [PCT_W-1:0] PCT_MAX = {PCT_W{1'b1}};
   localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

   typedef struct packed {
      logic [NS_W-1:0]   period;
      logic [FRAC_W-1:0] fraction;
   } cfg_type;

   typedef struct packed {
      logic [CNT_W-1:0] count;
      logic [SUM_W-1:0] interval_total;
      logic [NS_W-1:0]  interval_peak;
      logic [SUM_W-1:0] jitter_total;
      logic [NS_W-1:0]  jitter_peak;
   } stats_type;

endpackage

// ===== hdl/ijhm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ijhm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/ijhm_front.sv =====
// Front end: accepts request beats and works out the histogram bucket of a sample.
// The bucket index comes from a reciprocal multiply followed by one correction step.
// Depends on ijhm_pkg.
module ijhm_front import ijhm_pkg::*; #(
   parameter int HIST_BUCKETS    = 64,
   parameter int BUCKET_WIDTH_NS = 262144
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  clear_done,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_cmd,
   input  logic [NS_W-1:0]                       req_interval_ns,
   output logic                                  push_valid,
   input  logic                                  push_ready,
   output logic [1+NS_W+$clog2(HIST_BUCKETS)-1:0] push_data
);

   localparam int IDX_W = $clog2(HIST_BUCKETS);
   localparam longint unsigned TOP = longint'(HIST_BUCKETS) * longint'(BUCKET_WIDTH_NS);
   localparam logic [NS_W:0] RECIP = (NS_W+1)'((64'd1 << NS_W) / 64'(BUCKET_WIDTH_NS));

   typedef enum logic [1:0] {F_IDLE, F_MUL, F_FIX, F_PUSH} state_type;

   state_type         state_ff;
   logic              cmd_ff;
   logic [NS_W-1:0]   ns_ff;
   logic [IDX_W-1:0]  quot_ff;

   logic [2*NS_W:0]   recip_prod;
   logic [NS_W-1:0]   base;
   logic [NS_W-1:0]   rem;
   logic              ge;
   logic              accept;

   assign req_ready  = (state_ff == F_IDLE) && clear_done;
   assign accept     = req_valid && req_ready;
   assign push_valid = (state_ff == F_PUSH);
   assign push_data  = {cmd_ff, ns_ff, quot_ff};

   // The truncated reciprocal gives a quotient that is exact or one short.
   assign recip_prod = (2*NS_W+1)'(ns_ff) * (2*NS_W+1)'(RECIP);
   assign base       = NS_W'(quot_ff) * NS_W'(BUCKET_WIDTH_NS);
   assign rem        = ns_ff - base;
   assign ge         = (rem >= NS_W'(BUCKET_WIDTH_NS));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         unique case (state_ff)
            F_IDLE: begin
               if (accept) begin
                  cmd_ff <= req_cmd;
                  ns_ff  <= req_interval_ns;
                  // Overflow samples land in the last bucket without dividing.
                  if (req_cmd == CMD_REPORT || 64'(req_interval_ns) >= TOP) begin
                     quot_ff  <= IDX_W'(HIST_BUCKETS - 1);
                     state_ff <= F_PUSH;
                  end else begin
                     state_ff <= F_MUL;
                  end
               end
            end
            F_MUL: begin
               quot_ff  <= recip_prod[NS_W +: IDX_W];
               state_ff <= F_FIX;
            end
            F_FIX: begin
               quot_ff  <= quot_ff + IDX_W'(ge);
               state_ff <= F_PUSH;
            end
            F_PUSH: begin
               if (push_ready) begin
                  state_ff <= F_IDLE;
               end
            end
            default: state_ff <= F_IDLE;
         endcase
      end
   end

endmodule

// ===== hdl/ijhm_queue.sv =====
// Two-entry queue that decouples the front end from the back end.
// No dependencies.
module ijhm_queue #(
   parameter int WIDTH = 39
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   logic [WIDTH-1:0] mem_ff [2];
   logic             wr_ptr_ff;
   logic             rd_ptr_ff;
   logic [1:0]       cnt_ff;
   logic             push;
   logic             pop;

   assign push_ready = (cnt_ff != 2'd2);
   assign pop_valid  = (cnt_ff != 2'd0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end

endmodule

// ===== hdl/ijhm_back.sv =====
// Back end: updates the statistics and histogram, walks the histogram for reports
// and holds the response register. Depends on ijhm_pkg and ijhm_ram.
module ijhm_back import ijhm_pkg::*; #(
   parameter int HIST_BUCKETS    = 64,
   parameter int BUCKET_WIDTH_NS = 262144
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  cfg_type                               cfg,
   input  logic                                  pop_valid,
   output logic                                  pop_ready,
   input  logic [1+NS_W+$clog2(HIST_BUCKETS)-1:0] pop_data,
   output logic                                  clear_done,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [PCT_W-1:0]                      rsp_pct,
   output stats_type                             stats
);

   localparam int IDX_W = $clog2(HIST_BUCKETS);
   localparam int ACC_W = CNT_W + IDX_W;
   localparam longint unsigned TOP = longint'(HIST_BUCKETS) * longint'(BUCKET_WIDTH_NS);
   localparam int TOP_W = $clog2(TOP + 1);
   localparam int SAT_W = (TOP_W > PCT_W) ? TOP_W : PCT_W;
   localparam logic [IDX_W-1:0] LAST = IDX_W'(HIST_BUCKETS - 1);

   typedef enum logic [2:0] {
      B_CLEAR, B_IDLE, B_READ, B_UPDATE, B_WANT, B_WALK, B_DRAIN, B_REPORT
   } state_type;

   function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                input logic [NS_W-1:0] b);
      logic [SUM_W:0] s;
      s = {1'b0, a} + (SUM_W+1)'(b);
      return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
   endfunction

   state_type         state_ff;
   logic [IDX_W-1:0]  addr_ff;
   logic [NS_W-1:0]   ns_ff;
   logic [NS_W-1:0]   dev_ff;
   logic [CNT_W-1:0]  want_ff;
   logic [ACC_W-1:0]  acc_ff;
   logic              found_ff;
   logic              rdv_ff;
   logic [TOP_W-1:0]  edge_ff;
   logic [TOP_W-1:0]  hit_ff;
   logic              rsp_valid_ff;
   logic [PCT_W-1:0]  pct_ff;
   stats_type         stats_ff;

   stats_type         stats_in;
   logic [NS_W-1:0]   dev_in;
   logic [CNT_W-1:0]  bucket_in;
   logic [SUM_W-1:0]  prod;
   logic [ACC_W-1:0]  acc_in;
   logic              hit;
   logic [TOP_W-1:0]  edge_sel;
   logic [SAT_W-1:0]  edge_ext;
   logic [PCT_W-1:0]  pct_in;
   logic              out_free;
   logic              rsp_load;
   logic              e_cmd;
   logic [NS_W-1:0]   e_ns;
   logic [IDX_W-1:0]  e_idx;
   logic              ram_we;
   logic [CNT_W-1:0]  ram_wdata;
   logic [CNT_W-1:0]  ram_rdata;

   assign e_cmd = pop_data[NS_W+IDX_W];
   assign e_ns  = pop_data[IDX_W +: NS_W];
   assign e_idx = pop_data[IDX_W-1:0];

   assign pop_ready  = (state_ff == B_IDLE);
   assign clear_done = (state_ff != B_CLEAR);
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign rsp_load   = ((state_ff == B_UPDATE) || (state_ff == B_REPORT)) && out_free;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_pct   = pct_ff;
   assign stats     = stats_ff;

   // Statistics after one sample; dev_ff was registered in the read cycle.
   assign dev_in = (ns_ff > cfg.period) ? ns_ff - cfg.period : cfg.period - ns_ff;

   always_comb begin
      stats_in                = stats_ff;
      stats_in.count          = (stats_ff.count == CNT_MAX) ? CNT_MAX : stats_ff.count + 1'b1;
      stats_in.interval_total = sat_add(stats_ff.interval_total, ns_ff);
      stats_in.jitter_total   = sat_add(stats_ff.jitter_total, dev_ff);
      if (ns_ff > stats_ff.interval_peak) begin
         stats_in.interval_peak = ns_ff;
      end
      if (dev_ff > stats_ff.jitter_peak) begin
         stats_in.jitter_peak = dev_ff;
      end
   end

   assign bucket_in = (ram_rdata == CNT_MAX) ? CNT_MAX : ram_rdata + 1'b1;
   assign prod      = SUM_W'(stats_ff.count) * SUM_W'(cfg.fraction);
   assign acc_in    = acc_ff + ACC_W'(ram_rdata);
   assign hit       = !found_ff && (acc_in > ACC_W'(want_ff));

   // With no bucket over the threshold the answer is the top of the histogram.
   assign edge_sel = found_ff ? hit_ff : TOP_W'(TOP);
   assign edge_ext = SAT_W'(edge_sel);
   assign pct_in   = (stats_ff.count == '0) ? '0 :
                     (edge_ext > SAT_W'(PCT_MAX)) ? PCT_MAX : edge_ext[PCT_W-1:0];

   assign ram_we    = (state_ff == B_CLEAR) || (state_ff == B_UPDATE && out_free);
   assign ram_wdata = (state_ff == B_CLEAR) ? '0 : bucket_in;

   ijhm_ram #(
      .WIDTH (CNT_W),
      .DEPTH (HIST_BUCKETS)
   ) u_hist (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (addr_ff),
      .wr_data (ram_wdata),
      .rd_addr (addr_ff),
      .rd_data (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_CLEAR;
         addr_ff      <= '0;
         rdv_ff       <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         stats_ff     <= '0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            B_CLEAR: begin
               if (addr_ff == LAST) begin
                  addr_ff  <= '0;
                  state_ff <= B_IDLE;
               end else begin
                  addr_ff <= addr_ff + 1'b1;
               end
            end
            B_IDLE: begin
               if (pop_valid) begin
                  if (e_cmd == CMD_REPORT) begin
                     state_ff <= B_WANT;
                  end else begin
                     addr_ff  <= e_idx;
                     ns_ff    <= e_ns;
                     state_ff <= B_READ;
                  end
               end
            end
            B_READ: begin
               dev_ff   <= dev_in;
               state_ff <= B_UPDATE;
            end
            B_UPDATE: begin
               if (out_free) begin
                  stats_ff <= stats_in;
                  pct_ff   <= '0;
                  state_ff <= B_IDLE;
               end
            end
            B_WANT: begin
               want_ff  <= prod[SUM_W-1:FRAC_W];
               acc_ff   <= '0;
               found_ff <= 1'b0;
               rdv_ff   <= 1'b0;
               edge_ff  <= TOP_W'(BUCKET_WIDTH_NS);
               addr_ff  <= '0;
               state_ff <= B_WALK;
            end
            B_WALK, B_DRAIN: begin
               // Read data arrives in the cycle after its address is issued.
               if (rdv_ff) begin
                  acc_ff  <= acc_in;
                  edge_ff <= edge_ff + TOP_W'(BUCKET_WIDTH_NS);
                  if (hit) begin
                     found_ff <= 1'b1;
                     hit_ff   <= edge_ff;
                  end
               end
               if (state_ff == B_WALK) begin
                  rdv_ff <= 1'b1;
                  if (addr_ff == LAST) begin
                     state_ff <= B_DRAIN;
                  end else begin
                     addr_ff <= addr_ff + 1'b1;
                  end
               end else begin
                  rdv_ff   <= 1'b0;
                  state_ff <= B_REPORT;
               end
            end
            B_REPORT: begin
               if (out_free) begin
                  pct_ff   <= pct_in;
                  state_ff <= B_IDLE;
               end
            end
            default: state_ff <= B_IDLE;
         endcase
      end
   end

endmodule

// ===== hdl/interval_jitter_histogram_monitor_core.sv =====
// A sample beat passes the front end states F_MUL, F_FIX and F_PUSH (F_PUSH alone for an
// interval past the last bucket edge), the queue, then the back end states B_READ and B_UPDATE;
// a report walks every histogram bucket before its response is loaded. The front end takes a
// new beat only after it has pushed the last one, and a report holds the back end for the walk.
// Reset: synchronous; a clearing pass zeroes the histogram, and req_ready stays low until it
// ends. Configuration writes are taken at any time.
module interval_jitter_histogram_monitor_core import ijhm_pkg::*; #(
   parameter int HIST_BUCKETS    = 64,
   parameter int BUCKET_WIDTH_NS = 262144
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_cmd,
   input  logic [NS_W-1:0]       req_interval_ns,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [PCT_W-1:0]      rsp_percentile_ns,
   output logic [CNT_W-1:0]      rsp_sample_count,
   output logic [SUM_W-1:0]      rsp_interval_total,
   output logic [NS_W-1:0]       rsp_interval_peak,
   output logic [SUM_W-1:0]      rsp_jitter_total,
   output logic [NS_W-1:0]       rsp_jitter_peak,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_idx,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int ENTRY_W = 1 + NS_W + $clog2(HIST_BUCKETS);

   cfg_type              cfg_ff;
   stats_type            stats;
   logic                 clear_done;
   logic                 push_valid;
   logic                 push_ready;
   logic [ENTRY_W-1:0]   push_data;
   logic                 pop_valid;
   logic                 pop_ready;
   logic [ENTRY_W-1:0]   pop_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.period   <= PERIOD_RST;
         cfg_ff.fraction <= FRACTION_RST;
      end else if (csr_we) begin
         unique case (csr_idx)
            REG_PERIOD:   cfg_ff.period   <= csr_wdata[NS_W-1:0];
            REG_FRACTION: cfg_ff.fraction <= csr_wdata[FRAC_W-1:0];
            default: ;
         endcase
      end
   end

   ijhm_front #(
      .HIST_BUCKETS    (HIST_BUCKETS),
      .BUCKET_WIDTH_NS (BUCKET_WIDTH_NS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .clear_done      (clear_done),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cmd         (req_cmd),
      .req_interval_ns (req_interval_ns),
      .push_valid      (push_valid),
      .push_ready      (push_ready),
      .push_data       (push_data)
   );

   ijhm_queue #(
      .WIDTH (ENTRY_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   ijhm_back #(
      .HIST_BUCKETS    (HIST_BUCKETS),
      .BUCKET_WIDTH_NS (BUCKET_WIDTH_NS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data),
      .clear_done (clear_done),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_pct    (rsp_percentile_ns),
      .stats      (stats)
   );

   assign rsp_sample_count   = stats.count;
   assign rsp_interval_total = stats.interval_total;
   assign rsp_interval_peak  = stats.interval_peak;
   assign rsp_jitter_total   = stats.jitter_total;
   assign rsp_jitter_peak    = stats.jitter_peak;

   // No beat may enter while the histogram is still being cleared.
   assert property (@(posedge clock) disable iff (reset) !clear_done |-> !req_ready)
      else $error("request accepted during histogram clear");

   // A percentile can only be reported once samples exist.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_percentile_ns == '0 || rsp_sample_count != '0))
      else $error("nonzero percentile with no samples");

   // The saturating interval sum never falls below the largest interval.
   assert property (@(posedge clock) disable iff (reset)
      rsp_interval_total >= SUM_W'(rsp_interval_peak))
      else $error("interval sum below interval peak");

   // The sample count never goes backwards.
   assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> rsp_sample_count >= $past(rsp_sample_count))
      else $error("sample count decreased");

endmodule

// ===== sim/tb_interval_jitter_histogram_monitor_core.sv =====
// Testbench for interval_jitter_histogram_monitor_core: directed and random sample and report
// beats under random stalls, each response checked against an in-bench statistics model.
// Depends on ijhm_pkg and the core RTL.
module tb_interval_jitter_histogram_monitor_core;
   import ijhm_pkg::*;

   localparam int unsigned HIST_N       = 64;
   localparam int unsigned BUCKET_NS    = 262144;
   localparam int unsigned CYCLE_LIMIT  = 500_000;
   localparam int unsigned DRAIN_CYCLES = 150;
   localparam int unsigned FULL_BEATS   = 20;
   localparam int unsigned RING_N       = 64;

   typedef struct packed {
      logic [PCT_W-1:0] percentile;
      stats_type        stats;
   } stats_report_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic                  req_cmd = CMD_SAMPLE;
   logic [NS_W-1:0]       req_interval_ns = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [PCT_W-1:0]      rsp_percentile_ns;
   logic [CNT_W-1:0]      rsp_sample_count;
   logic [SUM_W-1:0]      rsp_interval_total;
   logic [NS_W-1:0]       rsp_interval_peak;
   logic [SUM_W-1:0]      rsp_jitter_total;
   logic [NS_W-1:0]       rsp_jitter_peak;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_idx = REG_PERIOD;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Bench copy of the block's configuration, statistics and histogram.
   cfg_type          model_cfg;
   stats_type        model_stats;
   logic [CNT_W-1:0] hist_bins [HIST_N];
   stats_report_type expected_ring [RING_N];

   int unsigned issue_count  = 0;
   int unsigned retire_count = 0;

   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned hold_left     = 0;
   int unsigned cycle_count   = 0;
   int unsigned mismatch_count = 0;
   int unsigned samples_sent  = 0;
   int unsigned reports_sent  = 0;
   int unsigned beats_checked = 0;
   int unsigned csr_writes    = 0;

   interval_jitter_histogram_monitor_core #(
      .HIST_BUCKETS    (HIST_N),
      .BUCKET_WIDTH_NS (BUCKET_NS)
   ) uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_cmd            (req_cmd),
      .req_interval_ns    (req_interval_ns),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_percentile_ns  (rsp_percentile_ns),
      .rsp_sample_count   (rsp_sample_count),
      .rsp_interval_total (rsp_interval_total),
      .rsp_interval_peak  (rsp_interval_peak),
      .rsp_jitter_total   (rsp_jitter_total),
      .rsp_jitter_peak    (rsp_jitter_peak),
      .csr_we             (csr_we),
      .csr_idx            (csr_idx),
      .csr_wdata          (csr_wdata)
   );

   always #6 clock = ~clock;

   function automatic int unsigned outstanding();
      return issue_count - retire_count;
   endfunction

   // Updates the bench statistics for one accepted beat and returns the response it implies.
   function automatic stats_report_type tally_beat(input logic cmd, input logic [NS_W-1:0] ns);
      stats_report_type rpt;
      logic [SUM_W:0]  wide_sum;
      logic [NS_W-1:0] dev;
      int unsigned     slot;
      int unsigned     b;
      logic [63:0]     want;
      logic [63:0]     acc;
      logic [63:0]     edge_ns;
      bit              hit;
      rpt.percentile = '0;
      if (cmd == CMD_SAMPLE) begin
         if (model_stats.count != CNT_MAX)
            model_stats.count = model_stats.count + 1'b1;
         wide_sum = {1'b0, model_stats.interval_total} + (SUM_W+1)'(ns);
         model_stats.interval_total = (wide_sum > (SUM_W+1)'(SUM_MAX)) ? SUM_MAX
                                                                       : wide_sum[SUM_W-1:0];
         if (ns > model_stats.interval_peak)
            model_stats.interval_peak = ns;
         dev = (ns > model_cfg.period) ? ns - model_cfg.period : model_cfg.period - ns;
         wide_sum = {1'b0, model_stats.jitter_total} + (SUM_W+1)'(dev);
         model_stats.jitter_total = (wide_sum > (SUM_W+1)'(SUM_MAX)) ? SUM_MAX
                                                                     : wide_sum[SUM_W-1:0];
         if (dev > model_stats.jitter_peak)
            model_stats.jitter_peak = dev;
         slot = ns / BUCKET_NS;
         if (slot >= HIST_N)
            slot = HIST_N - 1;
         if (hist_bins[slot] != CNT_MAX)
            hist_bins[slot] = hist_bins[slot] + 1'b1;
      end else if (model_stats.count != 0) begin
         want    = (64'(model_stats.count) * 64'(model_cfg.fraction)) >> 16;
         edge_ns = 64'(HIST_N) * 64'(BUCKET_NS);
         acc     = '0;
         hit     = 1'b0;
         for (b = 0; b < HIST_N; b++) begin
            if (!hit) begin
               acc = acc + 64'(hist_bins[b]);
               if (acc > want) begin
                  edge_ns = 64'(b + 1) * 64'(BUCKET_NS);
                  hit     = 1'b1;
               end
            end
         end
         rpt.percentile = (edge_ns > 64'(PCT_MAX)) ? PCT_MAX : edge_ns[PCT_W-1:0];
      end
      rpt.stats = model_stats;
      return rpt;
   endfunction

   function automatic void check_field(input string name, input logic [SUM_W-1:0] exp_v,
                                       input logic [SUM_W-1:0] got_v);
      if (got_v !== exp_v) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("mismatch on %s: expected %0d, got %0d", name, exp_v, got_v);
      end
   endfunction

   // The response check runs before the prediction, so a beat accepted at this edge
   // never pairs with a response leaving at the same edge.
   always @(posedge clock) begin
      stats_report_type head;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (outstanding() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("response with nothing expected: pct %0d count %0d",
                           rsp_percentile_ns, rsp_sample_count);
            end else begin
               head = expected_ring[retire_count % RING_N];
               retire_count++;
               check_field("percentile_ns", SUM_W'(head.percentile),
                           SUM_W'(rsp_percentile_ns));
               check_field("sample_count", SUM_W'(head.stats.count),
                           SUM_W'(rsp_sample_count));
               check_field("interval_total", head.stats.interval_total, rsp_interval_total);
               check_field("interval_peak", SUM_W'(head.stats.interval_peak),
                           SUM_W'(rsp_interval_peak));
               check_field("jitter_total", head.stats.jitter_total, rsp_jitter_total);
               check_field("jitter_peak", SUM_W'(head.stats.jitter_peak),
                           SUM_W'(rsp_jitter_peak));
               beats_checked++;
            end
         end
         if (req_valid && req_ready) begin
            expected_ring[issue_count % RING_N] = tally_beat(req_cmd, req_interval_ns);
            issue_count++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, outstanding());
         $display("** interval_jitter_histogram_monitor_core: FAILED **");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Called at a falling edge; returns at the falling edge after acceptance with valid still high.
   task automatic send_beat(input logic cmd, input logic [NS_W-1:0] ns);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_cmd         <= cmd;
      req_interval_ns <= ns;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      @(negedge clock);
      if (cmd == CMD_SAMPLE)
         samples_sent++;
      else
         reports_sent++;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(negedge clock);
      while (outstanding() != 0)
         @(negedge clock);
   endtask

   task automatic set_config(input logic [NS_W-1:0] period,
                             input logic [CSR_DATA_W-1:0] fraction_word);
      wait_idle();
      csr_we    <= 1'b1;
      csr_idx   <= REG_PERIOD;
      csr_wdata <= period;
      @(negedge clock);
      csr_idx   <= REG_FRACTION;
      csr_wdata <= fraction_word;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
      model_cfg.period   = period;
      model_cfg.fraction = fraction_word[FRAC_W-1:0];
      csr_writes += 2;
   endtask

   // Mostly intervals around the nominal period, with bucket edges and full-range values mixed in.
   function automatic logic [NS_W-1:0] pick_interval();
      case ($urandom_range(9))
         0:       return $urandom();
         1:       return $urandom_range(HIST_N) * BUCKET_NS - $urandom_range(1);
         2, 3:    return $urandom_range(HIST_N * BUCKET_NS + 1000);
         default: return model_cfg.period + $urandom_range(4_000_000) - 2_000_000;
      endcase
   endfunction

   task automatic send_random_beat();
      if ($urandom_range(99) < 15)
         send_beat(CMD_REPORT, $urandom());
      else
         send_beat(CMD_SAMPLE, pick_interval());
   endtask

   task automatic test_empty_report();
      send_beat(CMD_REPORT, 32'hFFFF_FFFF);
      send_beat(CMD_REPORT, 32'h0000_0000);
   endtask

   task automatic test_directed_extremes();
      send_beat(CMD_SAMPLE, 32'd0);
      send_beat(CMD_SAMPLE, BUCKET_NS - 1);
      send_beat(CMD_SAMPLE, BUCKET_NS);
      send_beat(CMD_SAMPLE, HIST_N * BUCKET_NS - 1);
      send_beat(CMD_SAMPLE, HIST_N * BUCKET_NS);
      send_beat(CMD_SAMPLE, 32'hFFFF_FFFF);
      send_beat(CMD_SAMPLE, PERIOD_RST);
      send_beat(CMD_REPORT, 32'd0);
      // A zero fraction picks the first occupied bucket.
      set_config(32'd0, 32'd0);
      send_beat(CMD_SAMPLE, 32'd5);
      send_beat(CMD_REPORT, 32'd0);
      set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_beat(CMD_SAMPLE, 32'd0);
      send_beat(CMD_REPORT, 32'd0);
      // Upper bits of the write data fall outside the fraction register.
      set_config(PERIOD_RST, 32'hABCD_8000);
      send_beat(CMD_REPORT, 32'd0);
      send_beat(CMD_SAMPLE, PERIOD_RST + 1);
   endtask

   task automatic test_random_traffic(input int unsigned beats, input int unsigned send_pct,
                                      input int unsigned recv_pct);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      repeat (beats)
         send_random_beat();
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      @(posedge clock);
      hold_left = 400;
      @(negedge clock);
      repeat (40)
         send_random_beat();
   endtask

   // With a zero period the jitter equals the interval, so both sums grow in full-range steps.
   task automatic test_full_range_sums();
      set_config(32'd0, 32'd65535);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      repeat (FULL_BEATS)
         send_beat(CMD_SAMPLE, 32'hFFFF_FFFF);
      send_beat(CMD_REPORT, 32'd0);
      set_config(32'd0, 32'd0);
      send_beat(CMD_SAMPLE, 32'd100);
      send_beat(CMD_REPORT, 32'd0);
   endtask

   initial begin
      model_cfg   = '{period: PERIOD_RST, fraction: FRACTION_RST};
      model_stats = '0;
      foreach (hist_bins[i])
         hist_bins[i] = '0;
      repeat (7)
         @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_empty_report();
      test_directed_extremes();
      set_config(PERIOD_RST, FRACTION_RST);
      test_random_traffic(240, 24, 83);
      set_config(32'd4_000_000, 32'd32768);
      test_random_traffic(240, 83, 24);
      set_config($urandom_range(20_000_000), $urandom());
      test_random_traffic(240, 0, 0);
      test_backpressure();
      test_full_range_sums();

      wait_idle();
      repeat (DRAIN_CYCLES)
         @(negedge clock);
      if (outstanding() != 0) begin
         mismatch_count += outstanding();
         $display("%0d responses never arrived", outstanding());
      end
      $display("Covered %0d sample and %0d report beats, %0d responses checked, %0d csr writes,",
               samples_sent, reports_sent, beats_checked, csr_writes);
      $display("including empty reports, bucket edges, a long response stall and full-range sums.");
      if (mismatch_count == 0) begin
         $display("** interval_jitter_histogram_monitor_core: PASSED **");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("** interval_jitter_histogram_monitor_core: FAILED **");
      end
      $finish;
   end

endmodule
